// ===== rtl/frame_fragment_packetizer_core_defines.svh =====
// Assertion shorthands shared by the packetizer RTL.
// Each expects clk and arst_n in scope.
`ifndef FRAME_FRAGMENT_PACKETIZER_CORE_DEFINES_SVH
`define FRAME_FRAGMENT_PACKETIZER_CORE_DEFINES_SVH

// same-cycle implication
`define FFP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packetizer check failed");

// next-cycle implication
`define FFP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packetizer check failed");

`endif

// ===== rtl/ffp_pkg.sv =====
package ffp_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_HDR,
		ST_PAY,
		ST_TRAIL
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	localparam int unsigned TAG_W = 31;
	localparam logic [15:0] CAP_RESET = 16'd1384;
	localparam logic [3:0] HDR_LAST = 4'd15;

	// header word order
	localparam logic [1:0] HW_TAG = 2'd0;
	localparam logic [1:0] HW_COUNT = 2'd1;
	localparam logic [1:0] HW_SIZE = 2'd2;
	localparam logic [1:0] HW_OFFSET = 2'd3;

	// register select, bit 2 of paddr
	localparam logic REG_CAP = 1'b0;

endpackage

// ===== rtl/ffp_div.sv =====
module ffp_div
	import ffp_pkg::*;
#(
	parameter int unsigned SIZE_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SIZE_BITS-1:0] dividend,
	input  logic [15:0]          divisor,
	output div_stat_t            stat,
	output logic [SIZE_BITS-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(SIZE_BITS);

	logic [15:0]          rem_q;
	logic [SIZE_BITS-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [16:0]          trial;
	logic                 ge;
	logic [16:0]          diff;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[SIZE_BITS-1]};
	assign ge = trial >= {1'b0, divisor};
	assign diff = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(SIZE_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[SIZE_BITS-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/frame_fragment_packetizer_core.sv =====
// Frame packetizer. Frame bytes enter one word at a time and leave as datagrams, each a
// 16-byte little-endian header (tag, packet count, frame size, byte offset) followed by
// up to payload_capacity payload bytes; a header-only datagram closes a frame whose size
// is a multiple of the capacity. The packet count comes from a restoring divider that
// runs once per frame, so the first byte of a frame waits for the division before its
// header starts. After that each byte, once the sink is ready, goes out alone in the
// middle of a datagram, behind a header when it opens one, and ahead of a header-only
// datagram when it closes an exactly filled frame.
// s_tready is high only between input words.
`include "frame_fragment_packetizer_core_defines.svh"

module frame_fragment_packetizer_core
	import ffp_pkg::*;
#(
	parameter int unsigned SIZE_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// data_byte, frame_size, frame_tag, zero pad
	input  logic [((8 + SIZE_BITS + 31 + 7) / 8) * 8 - 1:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_byte
	output logic [7:0]  m_tdata,
	// datagram_end, frame_end
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t state_q, state_d;

	logic                 in_frame_q;
	logic [7:0]           data_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [TAG_W-1:0]     tag_q;
	logic [SIZE_BITS:0]   total_q;
	logic [SIZE_BITS-1:0] off_q;
	logic [15:0]          fill_q;
	logic [3:0]           hdr_idx_q;
	logic [15:0]          cap_q;

	logic       m_tvalid_q;
	logic [7:0] obyte_q;
	logic       odend_q;
	logic       ofend_q;
	logic       olast_q;

	logic                 accept;
	logic                 out_free;
	logic [15:0]          cap_eff;
	logic [SIZE_BITS-1:0] in_size;
	logic [SIZE_BITS-1:0] in_size_fix;
	logic [SIZE_BITS:0]   off_inc;
	logic [15:0]          fill_inc;
	logic                 last_byte;
	logic                 dgram_full;
	logic [31:0]          hdr_word;
	logic [7:0]           hdr_byte;

	logic       emit;
	logic [7:0] e_byte;
	logic       e_dend;
	logic       e_fend;
	logic       e_last;

	div_stat_t            div_stat;
	logic                 div_start;
	logic [SIZE_BITS-1:0] div_quo;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign cap_eff = (cap_q == '0) ? 16'd1 : cap_q;

	assign in_size = s_tdata[8 +: SIZE_BITS];
	assign in_size_fix = (in_size == '0) ? SIZE_BITS'(1) : in_size;
	assign div_start = accept && !in_frame_q;

	assign off_inc = {1'b0, off_q} + 1'b1;
	assign fill_inc = fill_q + 16'd1;
	assign last_byte = off_inc >= {1'b0, size_q};
	assign dgram_full = fill_inc >= cap_eff;

	always_comb begin
		case (hdr_idx_q[3:2])
			HW_TAG:    hdr_word = 32'(tag_q);
			HW_COUNT:  hdr_word = 32'(total_q);
			HW_SIZE:   hdr_word = 32'(size_q);
			HW_OFFSET: hdr_word = 32'(off_q);
			default:   hdr_word = '0;
		endcase
	end

	assign hdr_byte = hdr_word[8 * hdr_idx_q[1:0] +: 8];

	ffp_div #(
		.SIZE_BITS(SIZE_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(in_size_fix),
		.divisor(cap_eff),
		.stat(div_stat),
		.quotient(div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!in_frame_q) begin
						state_d = ST_DIV;
					end else if (fill_q == '0) begin
						state_d = ST_HDR;
					end else begin
						state_d = ST_PAY;
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_HDR;
				end
			end
			ST_HDR: begin
				if (out_free && hdr_idx_q == HDR_LAST) begin
					state_d = ST_PAY;
				end
			end
			ST_PAY: begin
				if (out_free) begin
					state_d = (last_byte && dgram_full) ? ST_TRAIL : ST_IDLE;
				end
			end
			ST_TRAIL: begin
				if (out_free && hdr_idx_q == HDR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output word for this cycle
	always_comb begin
		emit = 1'b0;
		e_byte = hdr_byte;
		e_dend = 1'b0;
		e_fend = 1'b0;
		e_last = 1'b0;
		case (state_q)
			ST_HDR: begin
				emit = out_free;
			end
			ST_PAY: begin
				emit = out_free;
				e_byte = data_q;
				e_dend = last_byte || dgram_full;
				e_fend = last_byte && !dgram_full;
				e_last = !(last_byte && dgram_full);
			end
			ST_TRAIL: begin
				emit = out_free;
				e_dend = (hdr_idx_q == HDR_LAST);
				e_fend = (hdr_idx_q == HDR_LAST);
				e_last = (hdr_idx_q == HDR_LAST);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			in_frame_q <= 1'b0;
			off_q <= '0;
			fill_q <= '0;
			hdr_idx_q <= '0;
			cap_q <= CAP_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && pready && paddr[2] == REG_CAP) begin
				cap_q <= pwdata[15:0];
			end
			if (div_start) begin
				in_frame_q <= 1'b1;
				off_q <= '0;
				fill_q <= '0;
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (emit && (state_q == ST_HDR || state_q == ST_TRAIL)) begin
				hdr_idx_q <= hdr_idx_q + 1'b1;
			end
			if (emit && state_q == ST_PAY) begin
				off_q <= off_inc[SIZE_BITS-1:0];
				fill_q <= (last_byte || dgram_full) ? 16'd0 : fill_inc;
				if (last_byte) begin
					in_frame_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= s_tdata[7:0];
		end
		if (div_start) begin
			size_q <= in_size_fix;
			tag_q <= s_tdata[8 + SIZE_BITS +: TAG_W];
		end
		if (state_q == ST_DIV && div_stat.done) begin
			total_q <= {1'b0, div_quo} + 1'b1;
		end
		if (emit) begin
			obyte_q <= e_byte;
			odend_q <= e_dend;
			ofend_q <= e_fend;
			olast_q <= e_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = obyte_q;
	assign m_tuser = {ofend_q, odend_q};
	assign m_tlast = olast_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAP) ? {16'd0, cap_q} : 32'd0;

	`FFP_ASSERT_IMP(a_fend_has_dend, m_tvalid && m_tuser[1], m_tuser[0])
	`FFP_ASSERT_NXT(a_first_byte_divides, accept && !in_frame_q, state_q == ST_DIV)
	`FFP_ASSERT_IMP(a_div_busy_in_div, div_stat.busy || div_stat.done, state_q == ST_DIV)
	`FFP_ASSERT_IMP(a_idle_hdr_idx, state_q == ST_IDLE, hdr_idx_q == '0)
	`FFP_ASSERT_IMP(a_trail_closes_frame, emit && state_q == ST_TRAIL && e_last, e_fend && e_dend)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import ffp_pkg::*;

	localparam int unsigned SIZE_BITS = 24;
	localparam int unsigned TDATA_W = ((8 + SIZE_BITS + 31 + 7) / 8) * 8;
	localparam logic [2:0] CAP_ADDR = {REG_CAP, 2'b00};
	localparam int unsigned SETTLE = 40;
	localparam int unsigned PHASE_ITEMS = 30;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [SIZE_BITS-1:0] size;
		logic [7:0] data;
	} frame_byte_t;

	typedef struct packed {
		logic [7:0] b;
		logic dend;
		logic fend;
		logic run_last;
	} dgram_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	frame_byte_t byte_q[$];
	dgram_word_t dgram_q[$];
	int unsigned item_cnt = 0;
	int unsigned errors = 0;
	logic no_gaps = 1'b0;

	// packetizer state as predicted
	logic [15:0] cap_reg = CAP_RESET;
	logic in_frame = 1'b0;
	logic [SIZE_BITS-1:0] offset_r = '0;
	logic [SIZE_BITS-1:0] size_r = '0;
	logic [15:0] fill_r = '0;
	logic [TAG_W-1:0] tag_r = '0;
	logic [31:0] count_r = '0;
	dgram_word_t burst[33];
	int burst_n;

	frame_fragment_packetizer_core #(.SIZE_BITS(SIZE_BITS)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic stage_header(input logic [SIZE_BITS-1:0] offs, input logic hdr_only);
		logic [31:0] w [4];
		int i;
		logic tail;
		w[HW_TAG] = 32'(tag_r);
		w[HW_COUNT] = count_r;
		w[HW_SIZE] = 32'(size_r);
		w[HW_OFFSET] = 32'(offs);
		for (i = 0; i < 16; i++) begin
			tail = hdr_only && (i == int'(HDR_LAST));
			burst[burst_n] = {w[i / 4][8 * (i % 4) +: 8], tail, tail, 1'b0};
			burst_n++;
		end
	endtask

	task automatic packetize_byte(input frame_byte_t it);
		logic [16:0] cap;
		logic [SIZE_BITS-1:0] sz;
		logic last, full;
		int i;
		cap = (cap_reg == '0) ? 17'd1 : {1'b0, cap_reg};
		burst_n = 0;
		if (!in_frame) begin
			sz = (it.size == '0) ? SIZE_BITS'(1) : it.size;
			size_r = sz;
			tag_r = it.tag;
			count_r = 32'(sz) / 32'(cap) + 32'd1;
			offset_r = '0;
			fill_r = '0;
			in_frame = 1'b1;
		end
		if (fill_r == '0)
			stage_header(offset_r, 1'b0);
		last = (32'(offset_r) + 32'd1) >= 32'(size_r);
		fill_r = fill_r + 16'd1;
		full = {1'b0, fill_r} >= cap;
		burst[burst_n] = {it.data, last | full, last & ~full, 1'b0};
		burst_n++;
		offset_r = offset_r + 1'b1;
		if (last || full)
			fill_r = '0;
		if (last) begin
			// exactly filled: closing header-only datagram
			if (full)
				stage_header(offset_r, 1'b1);
			in_frame = 1'b0;
			offset_r = '0;
			fill_r = '0;
		end
		burst[burst_n - 1].run_last = 1'b1;
		for (i = 0; i < burst_n; i++)
			dgram_q.push_back(burst[i]);
	endtask

	task automatic report_bad(input string what, input dgram_word_t want, input dgram_word_t got);
		errors++;
		if (errors <= 10)
			$display("%0t %s: want byte %02h dend %b fend %b last %b, got byte %02h dend %b fend %b last %b",
				$realtime, what, want.b, want.dend, want.fend, want.run_last,
				got.b, got.dend, got.fend, got.run_last);
	endtask

	// driver: front of byte_q is the word on the bus
	always @(posedge clk or negedge arst_n) begin
		logic [TDATA_W-1:0] word;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				packetize_byte(byte_q.pop_front());
			if (!(s_tvalid && !s_tready)) begin
				if (byte_q.size() != 0 && (no_gaps || $urandom_range(99) >= 13)) begin
					word = '0;
					word[$bits(frame_byte_t)-1:0] = byte_q[0];
					s_tvalid <= 1'b1;
					s_tdata <= word;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= no_gaps || ($urandom_range(99) >= 13);
	end

	// monitor
	always @(posedge clk) begin
		dgram_word_t got;
		dgram_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata, m_tuser[0], m_tuser[1], m_tlast};
			if (dgram_q.size() == 0) begin
				report_bad("unexpected word", '0, got);
			end else begin
				want = dgram_q.pop_front();
				if (got != want)
					report_bad("mismatch", want, got);
			end
		end
	end

	task automatic apb_write(input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_reg = value;
	endtask

	// later words of a frame carry noise in the size and tag fields
	task automatic queue_frame(input int unsigned size, input int unsigned n_send);
		frame_byte_t it;
		int unsigned i;
		for (i = 0; i < n_send; i++) begin
			it.data = 8'($urandom);
			it.size = (i == 0) ? SIZE_BITS'(size) : SIZE_BITS'($urandom);
			it.tag = TAG_W'($urandom);
			byte_q.push_back(it);
		end
		item_cnt += n_send;
	endtask

	function automatic int unsigned pick_size(input int unsigned cap);
		int unsigned r;
		r = $urandom_range(39);
		if (r < 12 && cap <= 32)
			return cap * $urandom_range(3, 1);
		else if (r < 37)
			return $urandom_range(48, 1);
		else if (r < 39)
			return 0;
		else
			return $urandom_range(400, 256);
	endfunction

	task automatic drain();
		while (byte_q.size() != 0 || s_tvalid || dgram_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int unsigned caps [8];
		int unsigned p, sz, start;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset capacity: single-byte frames, zero size, field extremes
		byte_q.push_back({TAG_W'(0), SIZE_BITS'(1), 8'h00});
		byte_q.push_back({{TAG_W{1'b1}}, SIZE_BITS'(0), 8'hFF});
		item_cnt += 2;
		drain();
		apb_write(16'd4);
		queue_frame(8, 8);
		queue_frame(5, 5);
		drain();
		// zero capacity behaves as one
		apb_write(16'd0);
		queue_frame(3, 3);
		drain();
		apb_write(16'hFFFF);
		queue_frame(2, 2);
		drain();

		caps[0] = 1;
		caps[1] = 2;
		caps[2] = 3;
		caps[3] = 5;
		caps[4] = 16;
		caps[5] = 16'hFFFF;
		caps[6] = $urandom_range(40, 1);
		caps[7] = $urandom_range(300, 1);
		for (p = 0; p < 8; p++) begin
			no_gaps = (p == 3);
			apb_write(16'(caps[p]));
			start = item_cnt;
			while (item_cnt - start < PHASE_ITEMS) begin
				sz = pick_size(caps[p]);
				queue_frame(sz, (sz == 0) ? 1 : sz);
			end
			drain();
		end
		no_gaps = 1'b0;

		// largest size at capacity one: packet count needs an extra bit; frame left open
		apb_write(16'd1);
		byte_q.push_back({{TAG_W{1'b1}}, {SIZE_BITS{1'b1}}, 8'($urandom)});
		item_cnt++;
		queue_frame(0, 11);
		drain();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
